>>> hw/rtl/gcd_pkg.sv
package gcd_pkg;

   localparam int PC_W = 3;

   typedef logic [PC_W-1:0] upc_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_A_ZERO,
      C_B_ZERO,
      C_BOTH_EVEN,
      C_A_EVEN,
      C_B_EVEN_NZ,
      C_A_GT_B
   } cond_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_SHIFT_BOTH,
      OP_SHIFT_A,
      OP_SHIFT_B,
      OP_SWAP,
      OP_SUB,
      OP_OUT_A,
      OP_OUT_B
   } op_type;

   typedef struct packed {
      cond_type cond;
      op_type   op;
      upc_type  target;
   } uword_type;

   typedef struct packed {
      logic a_zero;
      logic b_zero;
      logic a_even;
      logic b_even;
      logic a_gt_b;
   } flags_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } ctl_type;

   localparam upc_type L_CHECK_A    = 3'd0;
   localparam upc_type L_CHECK_B    = 3'd1;
   localparam upc_type L_COMMON_TWO = 3'd2;
   localparam upc_type L_ODD_A      = 3'd3;
   localparam upc_type L_REDUCE     = 3'd4;
   localparam upc_type L_FINISH     = 3'd5;
   localparam upc_type L_ORDER      = 3'd6;
   localparam upc_type L_SUBTRACT   = 3'd7;

   // Each step runs its operation and jumps to its target when the condition
   // holds; otherwise it falls through to the next step.
   function automatic uword_type ucode_fetch(input upc_type pc);
      uword_type w;
      unique case (pc)
         L_CHECK_A:    w = '{cond: C_A_ZERO,    op: OP_OUT_B,      target: L_CHECK_A};
         L_CHECK_B:    w = '{cond: C_B_ZERO,    op: OP_OUT_A,      target: L_CHECK_A};
         L_COMMON_TWO: w = '{cond: C_BOTH_EVEN, op: OP_SHIFT_BOTH, target: L_COMMON_TWO};
         L_ODD_A:      w = '{cond: C_A_EVEN,    op: OP_SHIFT_A,    target: L_ODD_A};
         L_REDUCE:     w = '{cond: C_B_EVEN_NZ, op: OP_SHIFT_B,    target: L_REDUCE};
         L_FINISH:     w = '{cond: C_B_ZERO,    op: OP_OUT_A,      target: L_CHECK_A};
         L_ORDER:      w = '{cond: C_A_GT_B,    op: OP_SWAP,       target: L_SUBTRACT};
         L_SUBTRACT:   w = '{cond: C_ALWAYS,    op: OP_SUB,        target: L_REDUCE};
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/gcd_useq.sv
module gcd_useq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                out_full,
   input  gcd_pkg::flags_type  flags,
   output gcd_pkg::ctl_type    ctl,
   output logic                busy,
   output logic                done
);
   import gcd_pkg::*;

   logic      busy_ff, busy_in;
   upc_type   pc_ff, pc_in;
   uword_type uword;
   logic      cond_true;
   logic      is_out;
   logic      hold;

   assign uword = ucode_fetch(pc_ff);

   always_comb begin
      unique case (uword.cond)
         C_ALWAYS:    cond_true = 1'b1;
         C_A_ZERO:    cond_true = flags.a_zero;
         C_B_ZERO:    cond_true = flags.b_zero;
         C_BOTH_EVEN: cond_true = flags.a_even && flags.b_even;
         C_A_EVEN:    cond_true = flags.a_even;
         C_B_EVEN_NZ: cond_true = flags.b_even && !flags.b_zero;
         C_A_GT_B:    cond_true = flags.a_gt_b;
         default:     cond_true = 1'b0;
      endcase
   end

   assign is_out = (uword.op == OP_OUT_A) || (uword.op == OP_OUT_B);
   // A finished result may not overwrite one that has not been taken yet.
   assign hold   = is_out && cond_true && out_full;

   always_comb begin
      ctl.load = start && !busy_ff;
      ctl.op   = OP_NOP;
      if (busy_ff && cond_true && !hold) begin
         ctl.op = uword.op;
      end
   end

   assign done = busy_ff && cond_true && is_out && !hold;
   assign busy = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = L_CHECK_A;
         end
      end else if (!hold) begin
         if (cond_true) begin
            pc_in = uword.target;
            if (is_out) begin
               busy_in = 1'b0;
            end
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= L_CHECK_A;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   a_start_at_entry: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> busy_ff && (pc_ff == L_CHECK_A))
      else $error("sequencer did not start at the entry step");

endmodule

>>> hw/rtl/gcd_dpath.sv
module gcd_dpath #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gcd_pkg::ctl_type       ctl,
   input  logic [DATA_WIDTH-1:0]  value_a,
   input  logic [DATA_WIDTH-1:0]  value_b,
   output gcd_pkg::flags_type     flags,
   output logic [DATA_WIDTH-1:0]  divisor
);
   import gcd_pkg::*;

   localparam int SHIFT_W = (DATA_WIDTH > 2) ? $clog2(DATA_WIDTH) : 1;

   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [SHIFT_W-1:0]    k_ff, k_in;
   logic [DATA_WIDTH-1:0] divisor_ff, divisor_in;

   assign flags.a_zero = (a_ff == '0);
   assign flags.b_zero = (b_ff == '0);
   assign flags.a_even = !a_ff[0];
   assign flags.b_even = !b_ff[0];
   assign flags.a_gt_b = (a_ff > b_ff);

   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      divisor_in = divisor_ff;
      if (ctl.load) begin
         a_in = value_a;
         b_in = value_b;
         k_in = '0;
      end else begin
         unique case (ctl.op)
            OP_NOP: begin
            end
            OP_SHIFT_BOTH: begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end
            OP_SHIFT_A: a_in = a_ff >> 1;
            OP_SHIFT_B: b_in = b_ff >> 1;
            OP_SWAP: begin
               a_in = b_ff;
               b_in = a_ff;
            end
            OP_SUB:   b_in = b_ff - a_ff;
            OP_OUT_A: divisor_in = a_ff << k_ff;
            OP_OUT_B: divisor_in = (b_ff == '0) ? DATA_WIDTH'(1) : b_ff;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      divisor_ff <= divisor_in;
   end

   assign divisor = divisor_ff;

   a_sub_ordered: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_SUB) |-> !flags.a_gt_b)
      else $error("subtraction would wrap below zero");

   a_result_nonzero: assert property (@(posedge clock) disable iff (reset)
      ((ctl.op == OP_OUT_A) || (ctl.op == OP_OUT_B)) |=> (divisor_ff != '0))
      else $error("result word is zero");

endmodule

>>> hw/rtl/greatest_common_divisor_top.sv
// The entry step outputs the second operand when the first is zero (1 when both are), and
// the next step outputs the first when only the second is zero; otherwise common factors of
// two are shifted out, the binary subtract loop runs, and the result is shifted back.
// Throughput: one word at a time; the next word is taken the cycle after the result has
// been written to the output register, which holds it while the next one runs.
// Synchronous reset clears the sequencer and the output valid, not the data.
module greatest_common_divisor_top #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_WIDTH-1:0] req_value_a,
   input  logic [DATA_WIDTH-1:0] req_value_b,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_divisor
);
   import gcd_pkg::*;

   ctl_type   ctl;
   flags_type flags;
   logic      busy;
   logic      done;
   logic      rsp_valid_ff, rsp_valid_in;

   gcd_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid),
      .out_full (rsp_valid_ff && !rsp_ready),
      .flags    (flags),
      .ctl      (ctl),
      .busy     (busy),
      .done     (done)
   );

   gcd_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .value_a (req_value_a),
      .value_b (req_value_b),
      .flags   (flags),
      .divisor (rsp_divisor)
   );

   assign req_ready    = !busy;
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(done))
      else $error("result word appeared without a finished computation");

endmodule

>>> test/tb_greatest_common_divisor_top.sv
module tb_greatest_common_divisor_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW          = 16;
   localparam int PHASE_WORDS = 300;
   localparam int PHASES      = 6;
   localparam int IDLE_PCT    = 17;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT     = 100;
   localparam int CALM_FIRST  = 900;
   localparam int CALM_LAST   = 1200;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE      = 100;

   typedef struct packed {
      logic [DW-1:0] a;
      logic [DW-1:0] b;
   } operand_pair_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [DW-1:0] req_value_a = '0;
   logic [DW-1:0] req_value_b = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [DW-1:0] rsp_divisor;

   operand_pair_type operand_queue[$];
   logic [DW-1:0]    expected_divisors[$];
   operand_pair_type next_pair;
   int               words_queued = 0;
   int               words_sent = 0;
   int               results_seen = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;
   int               quiet_cycles = 0;
   int               errors = 0;

   greatest_common_divisor_top #(.DATA_WIDTH(DW)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value_a (req_value_a),
      .req_value_b (req_value_b),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_divisor (rsp_divisor)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Euclid's method; two zero operands give 1.
   function automatic logic [DW-1:0] divisor_of(input logic [DW-1:0] a, input logic [DW-1:0] b);
      logic [DW-1:0] x;
      logic [DW-1:0] y;
      logic [DW-1:0] r;
      x = a;
      y = b;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      if (x == 0) begin
         x = DW'(1);
      end
      return x;
   endfunction

   function automatic operand_pair_type random_pair();
      operand_pair_type p;
      int unsigned      kind;
      int unsigned      g;
      kind = $urandom_range(9);
      case (kind)
         4, 5: begin
            g = $urandom_range(1, 4095);
            p.a = DW'(g * $urandom_range(0, 65535 / g));
            p.b = DW'(g * $urandom_range(0, 65535 / g));
         end
         6: begin
            p.a = DW'($urandom_range(1, 255) << $urandom_range(0, 8));
            p.b = DW'($urandom_range(1, 255) << $urandom_range(0, 8));
         end
         7: begin
            p.a = DW'($urandom);
            p.b = '0;
            if ($urandom_range(1) == 1) begin
               p.b = p.a;
               p.a = '0;
            end
         end
         8: begin
            p.a = DW'($urandom);
            p.b = DW'(p.a * $urandom_range(1, 3));
         end
         9: begin
            p.a = DW'($urandom_range(0, 15));
            p.b = DW'($urandom_range(0, 15));
         end
         default: begin
            p.a = DW'($urandom);
            p.b = DW'($urandom);
         end
      endcase
      return p;
   endfunction

   task automatic queue_pair(input logic [DW-1:0] a, input logic [DW-1:0] b);
      operand_pair_type p;
      p.a = a;
      p.b = b;
      operand_queue.push_back(p);
      words_queued++;
   endtask

   task automatic wait_for_drain();
      while (results_seen != words_queued) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_divisors.push_back(divisor_of(req_value_a, req_value_b));
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (operand_queue.size() != 0 &&
                ((words_sent >= CALM_FIRST && words_sent < CALM_LAST) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               next_pair = operand_queue.pop_front();
               req_valid <= 1'b1;
               req_value_a <= next_pair.a;
               req_value_b <= next_pair.b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_divisors.size() == 0) begin
               $error("unexpected result word, divisor %0d", rsp_divisor);
               errors++;
            end else begin
               if (rsp_divisor !== expected_divisors[0]) begin
                  $error("divisor mismatch: expected %0d, actual %0d",
                         expected_divisors[0], rsp_divisor);
                  errors++;
               end
               void'(expected_divisors.pop_front());
            end
            results_seen++;
         end
         // A long receiver stall lets the block fill up and back-pressure the sender.
         if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                         ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_pair(16'h0000, 16'h0000);
      queue_pair(16'h0000, 16'h0001);
      queue_pair(16'h0001, 16'h0000);
      queue_pair(16'h0000, 16'hFFFF);
      queue_pair(16'hFFFF, 16'h0000);
      queue_pair(16'hFFFF, 16'hFFFF);
      queue_pair(16'h0001, 16'h0001);
      queue_pair(16'hFFFF, 16'h0001);
      queue_pair(16'h0001, 16'hFFFF);
      queue_pair(16'h8000, 16'h8000);
      queue_pair(16'h8000, 16'h4000);
      queue_pair(16'h0002, 16'h8000);
      queue_pair(16'hFFFE, 16'hFFFF);
      queue_pair(16'd65521, 16'd65519);
      queue_pair(16'd48, 16'd18);
      queue_pair(16'd18, 16'd48);
      queue_pair(16'd12, 16'h8000);
      queue_pair(16'hAAAA, 16'h5555);
      queue_pair(16'h5555, 16'hAAAA);
      queue_pair(16'd46368, 16'd28657);
      queue_pair(16'hFFFF, 16'hFFF0);
      queue_pair(16'h0000, 16'h8000);
      wait_for_drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         for (int i = 0; i < PHASE_WORDS; i++) begin
            operand_queue.push_back(random_pair());
            words_queued++;
         end
         wait_for_drain();
      end

      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && expected_divisors.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
